// ===== sv/tka_pkg.sv =====
// shared types and constants for the k-th ancestor lifting block
`timescale 1ns / 1ps
`default_nettype none

package tka_pkg;

   localparam int NODE_W  = 11;
   localparam int COUNT_W = 11;
   localparam int STEPS_W = 32;

   typedef logic [1:0] action_type;

   localparam action_type ACT_WRITE = 2'd0;
   localparam action_type ACT_BUILD = 2'd1;
   localparam action_type ACT_QUERY = 2'd2;

   typedef struct packed {
      action_type          action;
      logic [NODE_W-1:0]   node;
      logic [NODE_W-1:0]   parent;
      logic [STEPS_W-1:0]  steps;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [NODE_W-1:0]   ancestor;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_B_RD1,
      ST_B_RD2,
      ST_B_WR,
      ST_Q_STEP,
      ST_Q_WAIT,
      ST_Q_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== sv/tree_kth_ancestor_lifting_top.sv =====
// k-th ancestor by binary lifting: sequencer over one table memory
//
// req channel (valid/ready) carries one item per beat: write parent, build
// table or ancestor query. rsp channel (valid/ready) carries one beat per
// query only. csr_wr_en/csr_wr_data set node_count, taken at once.
// the table is one memory of NODES rows, each row holding all LEVELS
// entries of a node; every step does at most one row read.
// after reset a clearing pass writes every row to zero, row by row,
// with req_ready low; csr writes are taken meanwhile.
// write: the parent is stored in ST_WRITE if the node is in range, then idle.
// query: the walk to the rsp beat is set by the chain of dependent table
// reads, one level a cycle plus one wait per taken level, and ends early when
// an ancestor is missing; out of range queries go straight to the answer.
// build: states B_RD1 and B_RD2 per node and level, plus B_WR when an
// ancestor exists there, set by the up to two dependent reads per entry.
// one item is in work at a time; req_ready is low while it runs.
// the rsp beat sits in an output register; a stalled receiver lets the
// block go on with writes and builds, and a following query waits at its
// end until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module tree_kth_ancestor_lifting_top
   import tka_pkg::*;
#(
   parameter int NODES  = 1024,
   parameter int LEVELS = 11
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_data,
   input  wire logic                csr_wr_en,
   input  wire logic [COUNT_W-1:0]  csr_wr_data
);

   localparam int IW   = $clog2(NODES);
   localparam int LVW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CNTW = $clog2(NODES + 1);
   localparam logic [32:0] REACH = 33'd1 << LEVELS;

   typedef logic [LEVELS-1:0][NODE_W-1:0] lift_row_type;

   lift_row_type lift_mem [NODES];

   state_type            state_ff, state_in;
   logic [IW-1:0]        row_ff, row_in;
   logic [LVW-1:0]       lvl_ff, lvl_in;
   logic [NODE_W-1:0]    cur_ff, cur_in;
   logic [LEVELS-1:0]    steps_ff, steps_in;
   logic                 ok_ff, ok_in;
   logic [CNTW-1:0]      count_ff, count_in;
   logic [COUNT_W-1:0]   node_count_ff;
   lift_row_type         rd_row_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 node_ok;
   logic                 steps_ok;
   logic                 last_row;
   logic                 last_lvl;
   logic                 clear_done;
   logic                 rsp_free;
   logic [LVW-1:0]       sel_lvl;
   logic [NODE_W-1:0]    rd_val;

   logic                 rd_en;
   logic [IW-1:0]        rd_addr;
   logic                 wr_en;
   logic                 wr_all;
   logic [IW-1:0]        wr_addr;
   logic [LVW-1:0]       wr_lane;
   logic [NODE_W-1:0]    wr_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign node_ok  = (req_data.node != '0) && (32'(req_data.node) <= 32'(NODES));
   assign steps_ok = (33'(req_data.steps) < 33'(NODES)) && (33'(req_data.steps) < REACH);

   assign last_row   = (32'(row_ff) + 32'd1) == 32'(count_ff);
   assign last_lvl   = 32'(lvl_ff) == 32'(LEVELS - 1);
   assign clear_done = 32'(row_ff) == 32'(NODES - 1);

   // build reads the level below the one it fills
   assign sel_lvl = (state_ff == ST_B_RD2 || state_ff == ST_B_WR) ?
                    (lvl_ff - LVW'(1)) : lvl_ff;
   assign rd_val  = rd_row_ff[sel_lvl];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ACT_WRITE: state_in = ST_WRITE;
                  ACT_BUILD: begin
                     if (LEVELS > 1 && node_count_ff != '0) state_in = ST_B_RD1;
                  end
                  ACT_QUERY: state_in = (node_ok && steps_ok) ? ST_Q_STEP : ST_Q_DONE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_WRITE: state_in = ST_IDLE;
         ST_B_RD1: state_in = ST_B_RD2;
         ST_B_RD2: begin
            if (rd_val != '0) begin
               state_in = ST_B_WR;
            end else begin
               state_in = (last_row && last_lvl) ? ST_IDLE : ST_B_RD1;
            end
         end
         ST_B_WR: state_in = (last_row && last_lvl) ? ST_IDLE : ST_B_RD1;
         ST_Q_STEP: begin
            if (steps_ff[lvl_ff]) begin
               state_in = ST_Q_WAIT;
            end else if (lvl_ff == '0) begin
               state_in = ST_Q_DONE;
            end
         end
         ST_Q_WAIT: begin
            if (rd_val == '0 || lvl_ff == '0) begin
               state_in = ST_Q_DONE;
            end else begin
               state_in = ST_Q_STEP;
            end
         end
         ST_Q_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      row_in       = row_ff;
      lvl_in       = lvl_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      ok_in        = ok_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = row_ff;
      wr_en        = 1'b0;
      wr_all       = 1'b0;
      wr_addr      = row_ff;
      wr_lane      = '0;
      wr_data      = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            wr_all = 1'b1;
            row_in = row_ff + IW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ACT_WRITE: begin
                     row_in = IW'(32'(req_data.node) - 32'd1);
                     ok_in  = node_ok;
                     cur_in = (32'(req_data.parent) <= 32'(NODES)) ? req_data.parent : '0;
                  end
                  ACT_BUILD: begin
                     count_in = (32'(node_count_ff) > 32'(NODES)) ?
                                CNTW'(NODES) : CNTW'(node_count_ff);
                     row_in   = '0;
                     lvl_in   = LVW'(1);
                  end
                  ACT_QUERY: begin
                     cur_in   = req_data.node;
                     steps_in = req_data.steps[LEVELS-1:0];
                     lvl_in   = LVW'(LEVELS - 1);
                     ok_in    = node_ok && steps_ok;
                  end
                  default: begin
                     ok_in = ok_ff;
                  end
               endcase
            end
         end
         ST_WRITE: begin
            wr_en   = ok_ff;
            wr_data = cur_ff;
         end
         ST_B_RD1: begin
            rd_en = 1'b1;
         end
         ST_B_RD2: begin
            if (rd_val != '0) begin
               rd_en   = 1'b1;
               rd_addr = IW'(32'(rd_val) - 32'd1);
            end else begin
               // no ancestor below means none above either
               wr_en   = 1'b1;
               wr_lane = lvl_ff;
               row_in  = last_row ? '0 : row_ff + IW'(1);
               lvl_in  = last_row ? lvl_ff + LVW'(1) : lvl_ff;
            end
         end
         ST_B_WR: begin
            wr_en   = 1'b1;
            wr_lane = lvl_ff;
            wr_data = rd_val;
            row_in  = last_row ? '0 : row_ff + IW'(1);
            lvl_in  = last_row ? lvl_ff + LVW'(1) : lvl_ff;
         end
         ST_Q_STEP: begin
            if (steps_ff[lvl_ff]) begin
               rd_en   = 1'b1;
               rd_addr = IW'(32'(cur_ff) - 32'd1);
            end else if (lvl_ff != '0) begin
               lvl_in = lvl_ff - LVW'(1);
            end
         end
         ST_Q_WAIT: begin
            if (rd_val == '0) begin
               ok_in = 1'b0;
            end else begin
               cur_in = rd_val;
               if (lvl_ff != '0) lvl_in = lvl_ff - LVW'(1);
            end
         end
         ST_Q_DONE: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.found    = ok_ff;
               rsp_data_in.ancestor = ok_ff ? cur_ff : '0;
            end
         end
         default: begin
            row_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         row_ff        <= '0;
         lvl_ff        <= '0;
         ok_ff         <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= COUNT_W'(1);
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         lvl_ff       <= lvl_in;
         ok_ff        <= ok_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) node_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      steps_ff    <= steps_in;
      rsp_data_ff <= rsp_data_in;
   end

   // lifting table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_all) begin
            lift_mem[wr_addr] <= '0;
         end else begin
            lift_mem[wr_addr][wr_lane] <= wr_data;
         end
      end
      if (rd_en) rd_row_ff <= lift_mem[rd_addr];
   end

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_Q_DONE))
      else $error("rsp beat raised outside query completion");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.found || rsp_data_ff.ancestor == '0))
      else $error("not found beat carries an ancestor");

   a_wait_after_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_Q_WAIT |-> $past(state_ff == ST_Q_STEP))
      else $error("query wait without a table read");

   a_build_row_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_B_RD1 |-> (32'(row_ff) < 32'(count_ff) && lvl_ff != '0))
      else $error("build walks outside its node range");

   a_query_cur_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_STEP && ok_ff) |-> cur_ff != '0)
      else $error("query walk holds no node");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the k-th ancestor lifting block
`timescale 1ns / 1ps

module testbench;
   import tka_pkg::*;

   localparam int NODES        = 1024;
   localparam int LEVELS       = 11;
   localparam int ITEM_TARGET  = 1650;
   localparam int HOLD_CYCLES  = 300;
   localparam int REPORT_LIMIT = 10;

   // spare action code, the block accepts and drops it
   localparam action_type ACT_NONE = 2'd3;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_wr_en;
   logic [COUNT_W-1:0]  csr_wr_data;

   // mirror of the lifting table, row 0 unused so that node n sits at index n
   logic [NODE_W-1:0]   lift_mirror [LEVELS][NODES+1];
   logic [COUNT_W-1:0]  node_limit;
   rsp_type             pending_answers [$];
   int                  mismatch_count = 0;
   int                  items_sent = 0;
   int                  settle_cycles = 4;
   bit                  sender_bursts = 1'b1;
   bit                  receiver_bursts = 1'b1;
   bit                  hold_request = 1'b0;

   tree_kth_ancestor_lifting_top #(
      .NODES  (NODES),
      .LEVELS (LEVELS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [NODE_W-1:0] mirror_entry(input int level, input int v);
      if (v < 1 || v > NODES) return '0;
      return lift_mirror[level][v];
   endfunction

   function automatic req_type make_item(input action_type act, input int node,
                                         input int parent, input logic [31:0] steps);
      req_type r;
      r.action = act;
      r.node   = NODE_W'(node);
      r.parent = NODE_W'(parent);
      r.steps  = steps;
      return r;
   endfunction

   // tracks accepted beats: updates the mirror and checks answers in order
   always @(posedge clock) begin : beat_monitor
      rsp_type           want;
      int                span;
      logic [NODE_W-1:0] cur;
      logic              ok;
      if (!reset && req_valid && req_ready) begin
         settle_cycles = 4;
         case (req_data.action)
            ACT_WRITE: begin
               if (req_data.node != 0 && req_data.node <= NODES)
                  lift_mirror[0][req_data.node] =
                     (req_data.parent <= NODES) ? req_data.parent : '0;
            end
            ACT_BUILD: begin
               span = (node_limit > NODES) ? NODES : int'(node_limit);
               for (int l = 1; l < LEVELS; l++)
                  for (int v = 1; v <= span; v++)
                     lift_mirror[l][v] = mirror_entry(l - 1, int'(mirror_entry(l - 1, v)));
               settle_cycles = 4 * LEVELS * span + 20;
            end
            ACT_QUERY: begin
               cur = req_data.node;
               ok  = (req_data.node != 0) && (req_data.node <= NODES)
                     && (req_data.steps < NODES) && ((req_data.steps >> LEVELS) == 0);
               // top level first, any missing ancestor ends the climb
               for (int l = LEVELS - 1; l >= 0; l--) begin
                  if (ok && req_data.steps[l]) begin
                     cur = mirror_entry(l, int'(cur));
                     if (cur == 0) ok = 1'b0;
                  end
               end
               want.found    = ok;
               want.ancestor = ok ? cur : '0;
               pending_answers = {pending_answers, want};
            end
            default: ;
         endcase
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: answer beat with none due: found=%0d ancestor=%0d",
                        $realtime, rsp_data.found, rsp_data.ancestor);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.found !== want.found || rsp_data.ancestor !== want.ancestor) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: answer mismatch: expected %0d/%0d, got %0d/%0d (found/ancestor)",
                           $realtime, want.found, want.ancestor,
                           rsp_data.found, rsp_data.ancestor);
            end
         end
      end
   end

   // receiver: short random stalls, or one long hold when asked
   initial begin
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (receiver_bursts && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // valid is left high after a beat, the next send or a drain decides its level
   task automatic send_item(input req_type item);
      int gap;
      gap = (sender_bursts && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      // writes and builds give no answer, so allow for one still running
      repeat (settle_cycles) @(posedge clock);
   endtask

   task automatic write_node_count(input int value);
      wait_answers();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= COUNT_W'(value);
      @(posedge clock);
      node_limit = COUNT_W'(value);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_noise(input int count);
      action_type act;
      act = action_type'($urandom_range(0, 3));
      // large builds are slow, keep stray ones to small trees
      if (act == ACT_BUILD && count > 64) act = ACT_NONE;
      send_item(make_item(act, $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom));
   endtask

   // one tree: set the count, write parents, build, then mostly queries
   task automatic run_tree_episode(input int count, input int queries);
      int          par;
      int          node;
      logic [31:0] steps;
      write_node_count(count);
      for (int v = 1; v <= count; v++) begin
         if ($urandom_range(0, 11) == 0) send_noise(count);
         if (v == 1 || (count <= 64 && $urandom_range(0, 5) == 0)) par = 0;
         else if ($urandom_range(0, 19) == 0) par = $urandom_range(1, NODES);
         else if (count > 64 && $urandom_range(0, 15) != 0) par = v - 1;
         else par = $urandom_range(1, v - 1);
         send_item(make_item(ACT_WRITE, v, par, 0));
      end
      send_item(make_item(ACT_BUILD, 0, 0, 0));
      for (int q = 0; q < queries; q++) begin
         node = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, count);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: steps = $urandom_range(0, count);
            6: steps = $urandom_range(0, 2047);
            7: steps = 32'd1 << $urandom_range(0, 31);
            default: steps = $urandom;
         endcase
         case ($urandom_range(0, 19))
            0, 1: send_item(make_item(ACT_WRITE, $urandom_range(1, count),
                                      $urandom_range(0, count), 0));
            2: begin
               if (count <= 64) send_item(make_item(ACT_BUILD, 0, 0, 0));
               else send_item(make_item(ACT_QUERY, node, 0, steps));
            end
            3: send_noise(count);
            default: send_item(make_item(ACT_QUERY, node, 0, steps));
         endcase
      end
   endtask

   task automatic check_empty_table();
      write_node_count(1);
      send_item(make_item(ACT_QUERY, 1, 0, 0));
      send_item(make_item(ACT_QUERY, NODES, 0, 0));
      send_item(make_item(ACT_QUERY, 5, 0, 1));
      send_item(make_item(ACT_QUERY, 0, 0, 0));
      send_item(make_item(ACT_QUERY, 2047, 0, 3));
   endtask

   task automatic check_chain_extremes();
      write_node_count(NODES);
      send_item(make_item(ACT_WRITE, 1024, 1023, 0));
      send_item(make_item(ACT_WRITE, 1023, 1022, 0));
      send_item(make_item(ACT_WRITE, 1022, 1021, 0));
      send_item(make_item(ACT_WRITE, 2, 1, 0));
      send_item(make_item(ACT_WRITE, 1, 0, 0));
      send_item(make_item(ACT_WRITE, 3, 2047, 32'hFFFF_FFFF));
      send_item(make_item(ACT_WRITE, 0, 7, 0));
      send_item(make_item(ACT_WRITE, 1500, 9, 0));
      send_item(make_item(ACT_NONE, 2047, 2047, 32'hFFFF_FFFF));
      send_item(make_item(ACT_BUILD, 0, 0, 0));
      send_item(make_item(ACT_QUERY, 1024, 0, 1));
      send_item(make_item(ACT_QUERY, 1024, 0, 3));
      send_item(make_item(ACT_QUERY, 1024, 0, 4));
      send_item(make_item(ACT_QUERY, 2, 0, 1));
      send_item(make_item(ACT_QUERY, 1024, 0, 1023));
      send_item(make_item(ACT_QUERY, 1024, 0, 1024));
      send_item(make_item(ACT_QUERY, 1024, 0, 32'hFFFF_FFFF));
      send_item(make_item(ACT_QUERY, 3, 0, 1));
      // count above the node range is clamped
      write_node_count(2047);
      send_item(make_item(ACT_BUILD, 0, 0, 0));
      // count of zero builds nothing, so upper levels stay stale
      write_node_count(0);
      send_item(make_item(ACT_WRITE, 2, 3, 0));
      send_item(make_item(ACT_BUILD, 0, 0, 0));
      send_item(make_item(ACT_QUERY, 2, 0, 2));
   endtask

   task automatic check_output_stall();
      write_node_count(8);
      for (int v = 1; v <= 8; v++) send_item(make_item(ACT_WRITE, v, v - 1, 0));
      send_item(make_item(ACT_BUILD, 0, 0, 0));
      hold_request = 1'b1;
      for (int q = 0; q < 12; q++)
         send_item(make_item(ACT_QUERY, 8, 0, $urandom_range(0, 9)));
      wait_answers();
   endtask

   task automatic run_random_trees();
      run_tree_episode($urandom_range(600, 720), 150);
      while (items_sent < ITEM_TARGET - 60) begin
         sender_bursts   = ($urandom_range(0, 3) != 0);
         receiver_bursts = ($urandom_range(0, 3) != 0);
         run_tree_episode($urandom_range(1, 48), $urandom_range(8, 40));
      end
   endtask

   task automatic run_unpaced_tail();
      sender_bursts   = 1'b0;
      receiver_bursts = 1'b0;
      run_tree_episode(24, 30);
   endtask

   initial begin
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      reset       <= 1'b1;
      for (int l = 0; l < LEVELS; l++)
         for (int v = 0; v <= NODES; v++)
            lift_mirror[l][v] = '0;
      node_limit = COUNT_W'(1);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      check_empty_table();
      check_chain_extremes();
      check_output_stall();
      run_random_trees();
      run_unpaced_tail();
      wait_answers();
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
sv/tka_pkg.sv
sv/tree_kth_ancestor_lifting_top.sv
tb/testbench.sv
